>>> src/sdw_pkg.sv
// Shared types and constants of the spike delay wheel.
package sdw_pkg;

   localparam int SYN_W   = 10;   // synapse index
   localparam int SRC_W   = 8;    // source table index
   localparam int FAN_W   = 4;    // position within a fan-out list
   localparam int FCNT_W  = 5;    // fan-out count, 0..16
   localparam int SLOT_W  = 6;    // ring slot index
   localparam int SDEP_W  = 6;    // position within a slot
   localparam int SCNT_W  = 7;    // slot count, 0..64
   localparam int DLY_W   = 6;
   localparam int NRN_W   = 16;
   localparam int TGT_W   = 11;
   localparam int OFS_W   = 10;

   localparam int MAX_SYNAPSES = 1 << SYN_W;
   localparam int MAX_SOURCES  = 1 << SRC_W;
   localparam int MAX_FANOUT   = 1 << FAN_W;
   localparam int RING_SLOTS   = 1 << SLOT_W;
   localparam int SLOT_DEPTH   = 1 << SDEP_W;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_SPIKE = 2'd1,
      OP_TICK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_RANGE     = 3'd1,
      ST_FAN_FULL  = 3'd2,
      ST_SLOT_FULL = 3'd3,
      ST_DELAY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      REG_SOURCE_FIRST = 2'd0,
      REG_SOURCE_LIMIT = 2'd1,
      REG_INDEX_OFFSET = 2'd2
   } reg_type;

   typedef struct packed {
      logic [1:0]       operation;
      logic [SYN_W-1:0] synapse_id;
      logic [NRN_W-1:0] neuron_id;
      logic [DLY_W-1:0] delay_steps;
   } req_type;

   typedef struct packed {
      logic [TGT_W-1:0] target_synapse;
      logic             entry_valid;
      logic             last;
      logic [2:0]       status;
   } rsp_type;

endpackage

>>> src/sdw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> src/spike_delay_wheel.sv
// Top level of the spike delay wheel: sequencer, tables and register port.
// One item is taken at a time and req_stall stays high until its last result
// beat has been taken. Each table RAM has a single read port with registered
// read data, so the sequencer steps through its table reads in turn.
// An in-range load reads the fan-out count and then writes the list entry; a
// clear, or a load or spike from outside the group, goes straight to its
// closing beat; a spike reads the fan-out count and then, for each entry of
// the list, reads the synapse, its delay and the target slot count and adds
// the synapse to that slot; a tick reads the slot count, then reads and emits
// one beat per slot entry, or a single closing beat for an empty slot. The
// sequencer returns to idle before the next item is taken, and a result beat
// is held while rsp_stall is high. No clearing pass follows reset: fan-out and
// slot counts carry one valid flop per entry, cleared by reset at once.
module spike_delay_wheel (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sdw_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sdw_pkg::rsp_type           rsp_data,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [sdw_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [sdw_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [sdw_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import sdw_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LD_RD, S_LD_WR, S_SP_CNT, S_SP_N, S_SP_FL, S_SP_DL,
      S_SP_SC, S_SP_SW, S_TK_CNT, S_TK_N, S_TK_RD, S_TK_OUT, S_EMIT
   } state_type;

   state_type state_ff;

   // Registers
   logic [NRN_W-1:0] first_ff, limit_ff;
   logic [OFS_W-1:0] ofs_ff;

   // Item context
   logic [1:0]        op_ff;
   logic [SYN_W-1:0]  syn_ff;
   logic [SRC_W-1:0]  src_ff;
   logic [DLY_W-1:0]  dly_ff;
   logic [2:0]        stat_ff;
   logic [SDEP_W-1:0] idx_ff;
   logic [SCNT_W-1:0] cnt_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] ring_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [MAX_SOURCES-1:0] fc_vld_ff;
   logic [RING_SLOTS-1:0]  sc_vld_ff;

   // RAM ports
   logic [FCNT_W-1:0] fc_rdata;
   logic [SYN_W-1:0]  fl_rdata, se_rdata;
   logic [DLY_W-1:0]  dt_rdata;
   logic [SCNT_W-1:0] sc_rdata;
   logic [SLOT_W-1:0] sc_raddr;
   logic              ld_wr, sp_wr;

   // Range check on the incoming neuron
   logic [NRN_W-1:0] rel;
   logic             in_range;
   logic             acc;
   logic [FCNT_W-1:0] fcount;
   logic [SCNT_W-1:0] scount;
   logic [SLOT_W-1:0] dslot;

   assign rel      = req_data.neuron_id - first_ff;
   assign in_range = (req_data.neuron_id >= first_ff) && (req_data.neuron_id < limit_ff)
                     && (rel[NRN_W-1:SRC_W] == '0);
   assign acc      = req_valid && !req_stall;
   assign fcount   = fc_vld_ff[src_ff] ? fc_rdata : '0;
   assign scount   = sc_vld_ff[slot_ff] ? sc_rdata : '0;
   assign dslot    = ring_ff + dt_rdata;
   assign sc_raddr = (state_ff == S_SP_SC) ? dslot : ring_ff;

   // Load writes when the list still has room; spike writes when the slot does.
   assign ld_wr = (state_ff == S_LD_WR) && !fcount[FCNT_W-1];
   assign sp_wr = (state_ff == S_SP_SW) && !scount[SCNT_W-1];

   sdw_ram #(.WIDTH(DLY_W), .DEPTH(MAX_SYNAPSES)) u_delay (
      .clock(clock), .wr_en(ld_wr), .wr_addr(syn_ff), .wr_data(dly_ff),
      .rd_addr(fl_rdata), .rd_data(dt_rdata));

   sdw_ram #(.WIDTH(SYN_W), .DEPTH(MAX_SOURCES*MAX_FANOUT)) u_fan_list (
      .clock(clock), .wr_en(ld_wr), .wr_addr({src_ff, fcount[FAN_W-1:0]}),
      .wr_data(syn_ff), .rd_addr({src_ff, idx_ff[FAN_W-1:0]}), .rd_data(fl_rdata));

   sdw_ram #(.WIDTH(FCNT_W), .DEPTH(MAX_SOURCES)) u_fan_cnt (
      .clock(clock), .wr_en(ld_wr), .wr_addr(src_ff), .wr_data(fcount + 1'b1),
      .rd_addr(src_ff), .rd_data(fc_rdata));

   sdw_ram #(.WIDTH(SYN_W), .DEPTH(RING_SLOTS*SLOT_DEPTH)) u_slot_ent (
      .clock(clock), .wr_en(sp_wr), .wr_addr({slot_ff, scount[SDEP_W-1:0]}),
      .wr_data(syn_ff), .rd_addr({ring_ff, idx_ff}), .rd_data(se_rdata));

   sdw_ram #(.WIDTH(SCNT_W), .DEPTH(RING_SLOTS)) u_slot_cnt (
      .clock(clock), .wr_en(sp_wr), .wr_addr(slot_ff), .wr_data(scount + 1'b1),
      .rd_addr(sc_raddr), .rd_data(sc_rdata));

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ring_ff      <= '0;
         fc_vld_ff    <= '0;
         sc_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (acc) begin
                  op_ff   <= req_data.operation;
                  syn_ff  <= req_data.synapse_id;
                  src_ff  <= rel[SRC_W-1:0];
                  dly_ff  <= req_data.delay_steps;
                  idx_ff  <= '0;
                  // Flag a load or spike from a neuron outside the group.
                  stat_ff <= (!in_range && (req_data.operation == OP_LOAD ||
                                            req_data.operation == OP_SPIKE))
                             ? ST_RANGE : ST_OK;
                  unique case (op_type'(req_data.operation))
                     OP_LOAD:  state_ff <= in_range ? S_LD_RD : S_EMIT;
                     OP_SPIKE: state_ff <= in_range ? S_SP_CNT : S_EMIT;
                     OP_TICK:  state_ff <= S_TK_CNT;
                     OP_CLEAR: begin
                        fc_vld_ff <= '0;
                        state_ff  <= S_EMIT;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_LD_RD: state_ff <= S_LD_WR;
            S_LD_WR: begin
               // Drop a load to a full list; else the RAMs take it this edge.
               if (fcount[FCNT_W-1]) begin
                  stat_ff <= ST_FAN_FULL;
               end else begin
                  fc_vld_ff[src_ff] <= 1'b1;
               end
               state_ff <= S_EMIT;
            end
            S_SP_CNT: state_ff <= S_SP_N;
            S_SP_N: begin
               cnt_ff   <= SCNT_W'(fcount);
               state_ff <= (fcount == '0) ? S_EMIT : S_SP_FL;
            end
            S_SP_FL: state_ff <= S_SP_DL;
            S_SP_DL: begin
               syn_ff   <= fl_rdata;
               state_ff <= S_SP_SC;
            end
            S_SP_SC: begin
               slot_ff  <= dslot;
               state_ff <= S_SP_SW;
            end
            S_SP_SW: begin
               if (scount[SCNT_W-1]) begin
                  stat_ff <= ST_SLOT_FULL;
               end else begin
                  sc_vld_ff[slot_ff] <= 1'b1;
               end
               idx_ff <= idx_ff + 1'b1;
               state_ff <= ({1'b0, idx_ff} + 1'b1 == cnt_ff) ? S_EMIT : S_SP_FL;
            end
            S_TK_CNT: begin
               slot_ff  <= ring_ff;
               state_ff <= S_TK_N;
            end
            S_TK_N: begin
               cnt_ff <= scount;
               sc_vld_ff[ring_ff] <= 1'b0;
               state_ff <= (scount == '0) ? S_EMIT : S_TK_RD;
            end
            S_TK_RD: state_ff <= S_TK_OUT;
            S_TK_OUT: begin
               rsp_ff.target_synapse <= TGT_W'(se_rdata) + TGT_W'(ofs_ff);
               rsp_ff.entry_valid    <= 1'b1;
               rsp_ff.last           <= ({1'b0, idx_ff} + 1'b1 == cnt_ff);
               rsp_ff.status         <= ST_OK;
               rsp_valid_ff          <= 1'b1;
               state_ff              <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff) begin
                  // Single closing beat of a non-tick item or an empty tick.
                  rsp_ff.target_synapse <= '0;
                  rsp_ff.entry_valid    <= 1'b0;
                  rsp_ff.last           <= 1'b1;
                  rsp_ff.status         <= stat_ff;
                  rsp_valid_ff          <= 1'b1;
               end else if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (op_ff == OP_TICK && !rsp_ff.last) begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_TK_RD;
                  end else begin
                     if (op_ff == OP_TICK) begin
                        ring_ff <= ring_ff + 1'b1;
                     end
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Register port
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         limit_ff <= NRN_W'(MAX_SOURCES);
         ofs_ff   <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            REG_SOURCE_FIRST: first_ff <= csr_pwdata[NRN_W-1:0];
            REG_SOURCE_LIMIT: limit_ff <= csr_pwdata[NRN_W-1:0];
            REG_INDEX_OFFSET: ofs_ff   <= csr_pwdata[OFS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SOURCE_FIRST: csr_prdata = CSR_DW'(first_ff);
         REG_SOURCE_LIMIT: csr_prdata = CSR_DW'(limit_ff);
         REG_INDEX_OFFSET: csr_prdata = CSR_DW'(ofs_ff);
         default:          csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   // Checks
   a_accept_stalls: assert property (@(posedge clock) disable iff (reset)
      acc |=> req_stall) else $error("item accepted without stalling");
   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_EMIT) else $error("beat outside emit");
   a_invalid_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.entry_valid |-> rsp_data.last &&
      rsp_data.target_synapse == '0) else $error("bad empty beat");
   a_ring_step: assert property (@(posedge clock) disable iff (reset)
      ring_ff != $past(ring_ff) |-> $past(op_ff) == OP_TICK)
      else $error("ring moved outside tick");
endmodule

>>> tb/spike_delay_wheel_tb.sv
// Self-checking testbench for the spike delay wheel: directed and random items.
`timescale 1ns / 1ps

module spike_delay_wheel_tb;
   import sdw_pkg::*;

   localparam int LIMIT_CYCLES = 600000;
   localparam int HOLD_CYCLES  = 400;
   localparam int REQ_W        = $bits(req_type);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   spike_delay_wheel u_top (.*);

   // 12 ns period
   always #6 clock = ~clock;

   // Shadow of the block's tables and registers.
   logic [DLY_W-1:0]  delay_of   [MAX_SYNAPSES];
   logic [SYN_W-1:0]  fan_syn    [MAX_SOURCES][MAX_FANOUT];
   int                fan_len    [MAX_SOURCES];
   logic [SYN_W-1:0]  slot_syn   [RING_SLOTS][SLOT_DEPTH];
   int                slot_len   [RING_SLOTS];
   logic [SLOT_W-1:0] wheel_pos;
   logic [15:0]       grp_first;
   logic [15:0]       grp_limit;
   logic [OFS_W-1:0]  out_offset;

   rsp_type pending_beats[$];
   int errors = 0;
   int items_sent = 0;
   int beats_seen = 0;
   int configs_done = 0;
   int cycles = 0;
   bit quiet = 0;       // no idling on either side
   int hold_reqs = 0;   // bumped by the stimulus to ask for a long receiver hold-off

   task automatic report(input string what);
      errors++;
      $display("ERROR @%0t: %s", $time, what);
   endtask

   // Return the source table row of a neuron, or -1 when outside the group or past the table.
   function automatic int source_row(input logic [15:0] nrn);
      if (nrn < grp_first || nrn >= grp_limit) return -1;
      if (int'(nrn - grp_first) >= MAX_SOURCES) return -1;
      return int'(nrn - grp_first);
   endfunction

   // Update the shadow state for one accepted item and queue its result beats.
   task automatic wheel_predict(input req_type r);
      rsp_type b;
      int row;
      int k;
      logic [SLOT_W-1:0] s;
      b = '0;
      b.last = 1'b1;
      b.status = ST_OK;
      unique case (r.operation)
         OP_LOAD: begin
            row = source_row(r.neuron_id);
            if (row < 0) b.status = ST_RANGE;
            else if (fan_len[row] >= MAX_FANOUT) b.status = ST_FAN_FULL;
            else begin
               delay_of[r.synapse_id] = r.delay_steps;
               fan_syn[row][fan_len[row]] = r.synapse_id;
               fan_len[row]++;
            end
            pending_beats = {pending_beats, b};
         end
         OP_SPIKE: begin
            row = source_row(r.neuron_id);
            if (row < 0) b.status = ST_RANGE;
            else begin
               for (k = 0; k < fan_len[row]; k++) begin
                  s = wheel_pos + delay_of[fan_syn[row][k]];
                  if (slot_len[s] >= SLOT_DEPTH) b.status = ST_SLOT_FULL;
                  else begin
                     slot_syn[s][slot_len[s]] = fan_syn[row][k];
                     slot_len[s]++;
                  end
               end
            end
            pending_beats = {pending_beats, b};
         end
         OP_TICK: begin
            if (slot_len[wheel_pos] == 0) pending_beats = {pending_beats, b};
            for (k = 0; k < slot_len[wheel_pos]; k++) begin
               b.target_synapse = TGT_W'(slot_syn[wheel_pos][k]) + TGT_W'(out_offset);
               b.entry_valid = 1'b1;
               b.last = (k == slot_len[wheel_pos] - 1);
               pending_beats = {pending_beats, b};
            end
            slot_len[wheel_pos] = 0;
            wheel_pos++;
         end
         default: begin
            foreach (fan_len[i]) fan_len[i] = 0;
            pending_beats = {pending_beats, b};
         end
      endcase
   endtask

   // Offer one beat, with random gaps in front; hold it until taken.
   task automatic send_item(input req_type r);
      if (!quiet && $urandom_range(0, 99) < 11) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      wheel_predict(r);
      items_sent++;
   endtask

   function automatic req_type make_item(input op_type op, input int syn,
                                         input int nrn, input int dly);
      req_type r;
      r.operation = op;
      r.synapse_id = SYN_W'(syn);
      r.neuron_id = NRN_W'(nrn);
      r.delay_steps = DLY_W'(dly);
      return r;
   endfunction

   // Wait out all outstanding beats, then write one register over APB.
   task automatic write_reg(input reg_type idx, input logic [31:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_beats.size() == 0);
      repeat (8) @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(4 * int'(idx));
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      unique case (idx)
         REG_SOURCE_FIRST: grp_first = value[15:0];
         REG_SOURCE_LIMIT: grp_limit = value[15:0];
         default: out_offset = value[OFS_W-1:0];
      endcase
      configs_done++;
   endtask

   task automatic set_group(input int first, input int limit, input int ofs);
      write_reg(REG_SOURCE_FIRST, first);
      write_reg(REG_SOURCE_LIMIT, limit);
      write_reg(REG_INDEX_OFFSET, ofs);
   endtask

   // Out-of-group items, then fill one fan-out list, overflow it, spike until a slot drops entries, tick and clear.
   task automatic test_fanout_and_slot_full();
      send_item(make_item(OP_LOAD, 5, 256, 3));      // just past the group
      send_item(make_item(OP_SPIKE, 0, 65535, 0));   // far outside
      for (int i = 0; i < MAX_FANOUT; i++)
         send_item(make_item(OP_LOAD, (i == 15) ? 1023 : i * 67, 3, 2));
      send_item(make_item(OP_LOAD, 9, 3, 63));       // list full
      for (int i = 0; i < 5; i++)
         send_item(make_item(OP_SPIKE, 0, 3, 0));    // fifth one overflows slot 2
      for (int i = 0; i < 3; i++)
         send_item(make_item(OP_TICK, 0, 0, 0));     // empty, empty, full slot
      send_item(make_item(OP_CLEAR, 0, 0, 0));
      send_item(make_item(OP_SPIKE, 0, 3, 0));       // list now empty
   endtask

   // Edges of the group range and the largest index offset.
   task automatic test_group_edges();
      set_group(65535, 65535, 1023);                 // empty group
      send_item(make_item(OP_LOAD, 1, 65535, 1));
      set_group(500, 10, 1023);                      // inverted group
      send_item(make_item(OP_LOAD, 1, 500, 1));
      set_group(0, 65535, 1023);                     // wider than the table
      send_item(make_item(OP_LOAD, 1, 256, 1));
      send_item(make_item(OP_LOAD, 1023, 255, 0));
      send_item(make_item(OP_SPIKE, 0, 255, 0));
      send_item(make_item(OP_TICK, 0, 0, 0));
   endtask

   // Mostly well-formed load, spike and tick traffic on a small neuron pool.
   task automatic run_random(input int count, input int base);
      req_type r;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         r = make_item(OP_TICK, $urandom_range(0, 1023), base + $urandom_range(0, 7),
                       ($urandom_range(0, 1)) ? $urandom_range(0, 7) : $urandom_range(0, 63));
         if (pick < 34) r.operation = OP_LOAD;
         else if (pick < 60) r.operation = OP_SPIKE;
         else if (pick < 90) r.operation = OP_TICK;
         else if (pick < 93) r.operation = OP_CLEAR;
         else r = req_type'(REQ_W'({$urandom, $urandom}));   // noise over every field bit
         send_item(r);
      end
   endtask

   // Receiver: random stalls, a quiet stretch, and long hold-offs on request.
   int hold_left = 0;
   int hold_done = 0;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_done != hold_reqs) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= hold_reqs;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 11);
      end
   end

   // Compare every taken result beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (pending_beats.size() == 0) begin
            report($sformatf("unexpected result beat %p", rsp_data));
         end else begin
            want = pending_beats.pop_front();
            if (rsp_data.target_synapse !== want.target_synapse)
               report($sformatf("target_synapse %0d, want %0d",
                                rsp_data.target_synapse, want.target_synapse));
            if (rsp_data.entry_valid !== want.entry_valid)
               report($sformatf("entry_valid %0b, want %0b",
                                rsp_data.entry_valid, want.entry_valid));
            if (rsp_data.last !== want.last)
               report($sformatf("last %0b, want %0b", rsp_data.last, want.last));
            if (rsp_data.status !== want.status)
               report($sformatf("status %0d, want %0d", rsp_data.status, want.status));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("spike_delay_wheel_tb NOT OK");
         $finish;
      end
   end

   initial begin
      foreach (fan_len[i]) fan_len[i] = 0;
      foreach (slot_len[i]) slot_len[i] = 0;
      wheel_pos = '0;
      grp_first = 16'd0;
      grp_limit = 16'd256;
      out_offset = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_fanout_and_slot_full();
      test_group_edges();

      set_group(0, 256, 0);
      run_random(130, 0);

      // Block fills up behind a long receiver hold-off.
      set_group(1000, 1100, 1023);
      hold_reqs++;
      run_random(130, 1000);

      // Stretch with no idling at all.
      set_group(65280, 65535, 517);
      quiet = 1;
      run_random(130, 65530);
      quiet = 0;

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_beats.size() == 0);
      repeat (300) @(posedge clock);
      if (pending_beats.size() != 0) report("results still outstanding");

      $display("Covered %0d items, %0d result beats, %0d register writes,",
               items_sent, beats_seen, configs_done);
      $display("including full lists, overflowing slots and empty or inverted groups.");
      if (errors == 0) begin
         $display("spike_delay_wheel_tb OK");
      end else begin
         $display("spike_delay_wheel_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
src/sdw_pkg.sv
src/sdw_ram.sv
src/spike_delay_wheel.sv
tb/spike_delay_wheel_tb.sv
